// ----- hdl/lbs_pkg.sv -----
// Package for the linear blend skinning unit: widths, constants and shared types.
// Depends on nothing; imported by the interface file and the top level.
`default_nettype none
package lbs_pkg;
  localparam int BONES_DEF   = 256;
  localparam int WORD_W      = 32;
  localparam int WEIGHT_W    = 17;
  // Wide enough for a translation plus three full 32x32 products shifted by 16.
  localparam int ACC_W       = 50;
  localparam int BONE_COUNT_W = 3;
  localparam logic [WEIGHT_W:0] ONE_Q16 = 18'sd65536;

  typedef struct packed {
    logic                 mode;
    logic [2:0]           bone_count;
    logic [31:0]          bone_indices;
    logic [50:0]          weights;
    logic [1:0]           target_row;
    logic signed [31:0]   pos_x;
    logic signed [31:0]   pos_y;
    logic signed [31:0]   pos_z;
    logic signed [31:0]   norm_x;
    logic signed [31:0]   norm_y;
    logic signed [31:0]   norm_z;
    logic                 batch_end;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [31:0] out_norm_x;
    logic signed [31:0] out_norm_y;
    logic signed [31:0] out_norm_z;
    logic               last_of_batch;
  } out_item_t;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(32'sh7FFF_FFFF);
    lo = ACC_W'(32'sh8000_0000);
    if (v > hi) return 32'sh7FFF_FFFF;
    else if (v < lo) return 32'sh8000_0000;
    else return v[31:0];
  endfunction
endpackage
`default_nettype wire

// ----- hdl/lbs_if.sv -----
// Valid/ready channel interfaces for the skinning unit.
// Depends on lbs_pkg for the payload types.
`default_nettype none
interface lbs_in_if import lbs_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lbs_out_if import lbs_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/linear_blend_vertex_skinning_unit.sv -----
// Top level of the linear blend skinning unit: bone table, sequencer and one shared MAC.
// Depends on lbs_pkg and the channel interfaces in lbs_if.sv.
//
//  Channel | Direction | Payload
//  in_     | sink      | mode, bone_count, bone_indices, weights, target_row, pos, norm, batch_end
//  out_    | source    | out_pos_x/y/z, out_norm_x/y/z, last_of_batch
//
// A load: the accepting cycle, then one table element written per cycle, x, y and z in turn.
// A skin step for one bone (or two equal bones) skips the blend; it is bounded by the one
// table read port and the single shared multiplier:
// per bone and component, four read-then-accumulate pairs (READ then MAC)
// (translation first), then, when blending, one weight multiply per component.
// Reset is synchronous and active low; the table holds no reset value.
// The result waits in an output register; while it is stalled, the following item
// is held in its final state and no further item is accepted.
`default_nettype none
module linear_blend_vertex_skinning_unit
  import lbs_pkg::*;
#(
  parameter int BONES = BONES_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  lbs_in_if.sink    in_ch,
  lbs_out_if.source out_ch
);
  localparam int DEPTH = BONES * 12;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_MAC   = 3'd3;
  localparam logic [2:0] ST_BLEND = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0] state_r, state_nxt;
  in_item_t   item_r;
  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_r;
  logic [1:0] elem_r;
  logic [1:0] bone_r;
  logic [2:0] comp_r;
  logic [2:0] term_r;
  logic [2:0] cnt_r;
  logic       single_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [31:0] tres_r [6];
  logic signed [ACC_W-1:0] blend_r [6];
  out_item_t  out_r;
  logic       out_valid_r;

  // Bone index and validity of the bone being worked on.
  logic [7:0] bidx;
  logic       bvalid;
  assign bidx   = item_r.bone_indices[8*bone_r +: 8];
  assign bvalid = 32'(bidx) < 32'(BONES);

  // Table address: term 0 reads the translation row 3, terms 1..3 read rows 0..2.
  logic [AW+1:0] addr_full;
  logic [1:0]    row_sel;
  logic [1:0]    col_sel;
  assign row_sel = (term_r == 3'd0) ? 2'd3 : 2'(term_r - 3'd1);
  assign col_sel = 2'(comp_r >= 3'd3 ? comp_r - 3'd3 : comp_r);
  assign addr_full = (AW+2)'((32'(bidx) * 4 + 32'(row_sel)) * 3 + 32'(col_sel));

  // Vector element of the current component pass.
  logic signed [31:0] vel;
  always_comb begin
    vel = '0;
    case (term_r)
      3'd1: vel = (comp_r < 3'd3) ? item_r.pos_x : item_r.norm_x;
      3'd2: vel = (comp_r < 3'd3) ? item_r.pos_y : item_r.norm_y;
      3'd3: vel = (comp_r < 3'd3) ? item_r.pos_z : item_r.norm_z;
      default: vel = '0;
    endcase
  end

  // Weight of the current bone.
  logic signed [WEIGHT_W+2:0] wgt;
  logic signed [WEIGHT_W+2:0] e0, e1, e2;
  always_comb begin
    e0 = (WEIGHT_W+3)'(item_r.weights[16:0]);
    e1 = (WEIGHT_W+3)'(item_r.weights[33:17]);
    e2 = (WEIGHT_W+3)'(item_r.weights[50:34]);
    wgt = '0;
    case (cnt_r)
      3'd2: wgt = (bone_r == 2'd0) ? (WEIGHT_W+3)'(ONE_Q16) - e0 : e0;
      3'd3: case (bone_r)
              2'd0: wgt = e0;
              2'd1: wgt = e1;
              default: wgt = (WEIGHT_W+3)'(ONE_Q16) - e0 - e1;
            endcase
      default: case (bone_r)
              2'd0: wgt = e0;
              2'd1: wgt = e1;
              2'd2: wgt = e2;
              default: wgt = (WEIGHT_W+3)'(ONE_Q16) - e0 - e1 - e2;
            endcase
    endcase
  end

  // Shared multiplier: matrix entry by vector element, or bone result by weight.
  logic signed [31:0] ma;
  logic signed [WORD_W:0] mb;
  logic signed [64:0] prod;
  logic signed [ACC_W-1:0] prod_sh;
  logic signed [31:0] entry_v;
  logic [2:0] bsel;
  assign entry_v = bvalid ? $signed(rd_r) : 32'sd0;
  assign bsel    = comp_r;
  always_comb begin
    if (state_r == ST_BLEND) begin
      ma = tres_r[bsel];
      mb = (WORD_W+1)'(wgt);
    end else begin
      ma = vel;
      mb = (WORD_W+1)'(entry_v);
    end
  end
  assign prod    = 65'(ma) * 65'(mb);
  assign prod_sh = ACC_W'(prod >>> 16);

  // Sequencer.
  logic [2:0] cnt_in;
  always_comb begin
    cnt_in = in_ch.data.bone_count;
    if (cnt_in == 3'd0) cnt_in = 3'd1;
    if (cnt_in > 3'd4) cnt_in = 3'd4;
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  logic in_xfer;
  assign in_xfer = in_ch.valid && in_ch.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_xfer) state_nxt = in_ch.data.mode ? ST_READ : ST_LOAD;
      ST_LOAD:  if (elem_r == 2'd2) state_nxt = ST_IDLE;
      ST_READ:  state_nxt = ST_MAC;
      ST_MAC: begin
        if (term_r == 3'd3 && comp_r == 3'd5) begin
          if (single_r) state_nxt = ST_OUT;
          else state_nxt = ST_BLEND;
        end else state_nxt = ST_READ;
      end
      ST_BLEND: begin
        if (comp_r == 3'd5) begin
          if (3'(bone_r) + 3'd1 == cnt_r) state_nxt = ST_OUT;
          else state_nxt = ST_READ;
        end
      end
      ST_OUT:   if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // Table write for loads; registered read for skinning.
  logic [AW+1:0] wr_full;
  logic [31:0]   wr_data;
  assign wr_full = (AW+2)'((32'(item_r.bone_indices[7:0]) * 4 + 32'(item_r.target_row)) * 3
                   + 32'(elem_r));
  always_comb begin
    case (elem_r)
      2'd0: wr_data = item_r.pos_x;
      2'd1: wr_data = item_r.pos_y;
      default: wr_data = item_r.pos_z;
    endcase
  end
  always_ff @(posedge clk) begin
    if (state_r == ST_LOAD && 32'(item_r.bone_indices[7:0]) < 32'(BONES))
      mem[wr_full[AW-1:0]] <= wr_data;
    rd_r <= mem[bvalid ? addr_full[AW-1:0] : '0];
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && (!out_valid_r || out_ch.ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        item_r   <= in_ch.data;
        elem_r   <= 2'd0;
        bone_r   <= 2'd0;
        comp_r   <= 3'd0;
        term_r   <= 3'd0;
        acc_r    <= '0;
        cnt_r    <= cnt_in;
        single_r <= (cnt_in == 3'd1) || (cnt_in == 3'd2 &&
                    in_ch.data.bone_indices[7:0] == in_ch.data.bone_indices[15:8]);
        for (int i = 0; i < 6; i++) blend_r[i] <= '0;
      end
      ST_LOAD: elem_r <= elem_r + 2'd1;
      ST_MAC: begin
        // Term 0 adds the translation (position only); others add a truncated product.
        logic signed [ACC_W-1:0] sum;
        if (term_r == 3'd0) sum = (comp_r < 3'd3) ? ACC_W'(entry_v) : '0;
        else sum = acc_r + prod_sh;
        if (term_r == 3'd3) begin
          tres_r[comp_r] <= sat32(sum);
          acc_r  <= '0;
          term_r <= 3'd0;
          comp_r <= (comp_r == 3'd5) ? 3'd0 : comp_r + 3'd1;
        end else begin
          acc_r  <= sum;
          term_r <= term_r + 3'd1;
        end
      end
      ST_BLEND: begin
        blend_r[comp_r] <= blend_r[comp_r] + prod_sh;
        if (comp_r == 3'd5) begin
          comp_r <= 3'd0;
          bone_r <= bone_r + 2'd1;
        end else comp_r <= comp_r + 3'd1;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_r.last_of_batch <= item_r.batch_end;
          if (single_r) begin
            out_r.out_pos_x  <= tres_r[0];
            out_r.out_pos_y  <= tres_r[1];
            out_r.out_pos_z  <= tres_r[2];
            out_r.out_norm_x <= tres_r[3];
            out_r.out_norm_y <= tres_r[4];
            out_r.out_norm_z <= tres_r[5];
          end else begin
            out_r.out_pos_x  <= sat32(blend_r[0]);
            out_r.out_pos_y  <= sat32(blend_r[1]);
            out_r.out_pos_z  <= sat32(blend_r[2]);
            out_r.out_norm_x <= sat32(blend_r[3]);
            out_r.out_norm_y <= sat32(blend_r[4]);
            out_r.out_norm_z <= sat32(blend_r[5]);
          end
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  // Checks on the sequencer.
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> state_r == ST_IDLE) else $error("ready outside idle");
  a_load_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD && elem_r == 2'd2) |=> state_r == ST_IDLE)
    else $error("load did not finish");
  a_bone_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_BLEND |-> 3'(bone_r) < cnt_r) else $error("bone counter overran");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid) else $error("result dropped");
endmodule
`default_nettype wire
